/* design/nco_pkg.sv */
// Shared types, register indexes and quarter-wave table generator for the oscillator.
`default_nettype none

package nco_pkg;

	// Configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_START_PHASE  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COMPLEX_MODE = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_LENGTH = 2'd3;

	// Register widths and reset values
	localparam int STEP_BITS      = 32;
	localparam int START_BITS     = 32;
	localparam int BLK_LEN_BITS   = 13;
	localparam logic [BLK_LEN_BITS-1:0] BLK_LEN_RESET = 13'd4096;

	// pi/2 in Q30, rounded
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Per-sample control that travels with the table lookup
	typedef struct packed {
		logic [1:0] quad;
		logic       block_end;
		logic       cplx;
	} ctrl_t;

	// Quarter-wave entry i: Q30 Taylor sine to the x^13 term, scaled to full
	// amplitude 2^(amp_bits-1)-1 with round half up, clamped to [0, A].
	function automatic logic [23:0] qwave_entry(input int unsigned i,
			input int unsigned addr_bits, input int unsigned amp_bits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        amp;
		logic [63:0]        v;
		logic signed [63:0] sum;
		x = ((64'(i) * HALF_PI_Q30) + ((64'd1 << addr_bits) >> 1)) >> addr_bits;
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(x);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k[0])
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 0)
			sum = 64'sd0;
		amp = (64'd1 << (amp_bits - 1)) - 64'd1;
		v = ((unsigned'(sum) * amp) + (64'd1 << 29)) >> 30;
		if (v > amp)
			v = amp;
		return v[23:0];
	endfunction

endpackage

`default_nettype wire

/* design/phase_accumulator_oscillator.sv */
// Pipeline: the accumulator and block counter update in the transfer cycle, the sine
// ROM read is registered, then the output register. Throughput: one sample per clock
// while the output is not stalled.
// A stalled output holds its sample while one more sample waits in the ROM stage.
// Reset: arst_n clears the accumulator, counter and pipeline valids and loads
// the register reset values (step 0, start 0, complex mode, block length 4096).
`default_nettype none

module phase_accumulator_oscillator #(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10,
	parameter int AMP_BITS        = 16,
	parameter int MAX_BLOCK       = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [nco_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [nco_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                restart,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [AMP_BITS-1:0]               cos_value,
	output logic signed [AMP_BITS-1:0]               sin_value,
	output logic                                     block_end
);
	import nco_pkg::*;

	logic                       take;
	logic                       en_s1;
	logic                       adv_s2;
	logic                       valid_s1;
	ctrl_t                      ctrl;
	ctrl_t                      ctrl_s1;
	logic [TABLE_ADDR_BITS:0]   sin_addr;
	logic [TABLE_ADDR_BITS:0]   cos_addr;
	logic [AMP_BITS-2:0]        sin_mag;
	logic [AMP_BITS-2:0]        cos_mag;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	// ROM stage loads when empty or when it moves on
	assign en_s1    = !valid_s1 || adv_s2;
	assign in_ready = en_s1;
	assign take     = in_valid && en_s1;

	nco_phase #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS),
		.MAX_BLOCK       (MAX_BLOCK)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.restart   (restart),
		.ctrl      (ctrl),
		.sin_addr  (sin_addr),
		.cos_addr  (cos_addr)
	);

	nco_rom #(
		.ADDR_BITS (TABLE_ADDR_BITS),
		.VAL_BITS  (AMP_BITS - 1)
	) u_rom (
		.clk    (clk),
		.en     (en_s1),
		.addr_a (sin_addr),
		.addr_b (cos_addr),
		.data_a (sin_mag),
		.data_b (cos_mag)
	);

	// ROM stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en_s1)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1)
			ctrl_s1 <= ctrl;
	end

	nco_out #(
		.AMP_BITS (AMP_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ctrl_s1   (ctrl_s1),
		.sin_mag   (sin_mag),
		.cos_mag   (cos_mag),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cos_value (cos_value),
		.sin_value (sin_value),
		.block_end (block_end),
		.adv       (adv_s2)
	);

endmodule

`default_nettype wire

/* design/nco_rom.sv */
// Two-port quarter-wave sine ROM with registered read data.
`default_nettype none

module nco_rom #(
	parameter int ADDR_BITS = 10,
	parameter int VAL_BITS  = 15
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [ADDR_BITS:0]   addr_a,
	input  wire logic [ADDR_BITS:0]   addr_b,
	output logic      [VAL_BITS-1:0]  data_a,
	output logic      [VAL_BITS-1:0]  data_b
);
	import nco_pkg::*;

	localparam int DEPTH = (1 << ADDR_BITS) + 1;

	typedef logic [VAL_BITS-1:0] rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < DEPTH; i++)
			r[i] = VAL_BITS'(qwave_entry(unsigned'(i), unsigned'(ADDR_BITS),
				unsigned'(VAL_BITS + 1)));
		return r;
	endfunction

	localparam rom_t QWAVE = build_rom();

	logic [VAL_BITS-1:0] rd_a_s1;
	logic [VAL_BITS-1:0] rd_b_s1;

	// Registered reads, held while the stage is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			rd_a_s1 <= QWAVE[addr_a];
			rd_b_s1 <= QWAVE[addr_b];
		end
	end

	assign data_a = rd_a_s1;
	assign data_b = rd_b_s1;

endmodule

`default_nettype wire

/* design/nco_phase.sv */
// Config registers, phase accumulator, block counter and table address generation.
`default_nettype none

module nco_phase #(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10,
	parameter int MAX_BLOCK       = 4096
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [nco_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [nco_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  wire logic                                  take,
	input  wire logic                                  restart,
	output nco_pkg::ctrl_t                             ctrl,
	output logic      [TABLE_ADDR_BITS:0]              sin_addr,
	output logic      [TABLE_ADDR_BITS:0]              cos_addr
);
	import nco_pkg::*;

	localparam int CNT_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int LEN_W = $clog2(MAX_BLOCK + 1) + 1;

	logic signed [STEP_BITS-1:0]    phase_step_q;
	logic        [START_BITS-1:0]   start_phase_q;
	logic                           complex_mode_q;
	logic        [BLK_LEN_BITS-1:0] block_length_q;

	logic [PHASE_BITS-1:0] phase_acc_q;
	logic [CNT_W-1:0]      count_q;

	logic [PHASE_BITS-1:0]      cur_phase;
	logic [CNT_W-1:0]           cur_count;
	logic [LEN_W-1:0]           eff_len;
	logic [LEN_W-1:0]           count_inc;
	logic                       last;
	logic [1:0]                 quad;
	logic [TABLE_ADDR_BITS-1:0] frac;
	logic [TABLE_ADDR_BITS:0]   addr_fwd;
	logic [TABLE_ADDR_BITS:0]   addr_rev;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= '0;
			start_phase_q  <= '0;
			complex_mode_q <= 1'b1;
			block_length_q <= BLK_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PHASE_STEP:   phase_step_q   <= signed'(STEP_BITS'(cfg_data));
				REG_START_PHASE:  start_phase_q  <= START_BITS'(cfg_data);
				REG_COMPLEX_MODE: complex_mode_q <= cfg_data[0];
				REG_BLOCK_LENGTH: block_length_q <= cfg_data[BLK_LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Phase and count seen by this sample (restart reloads first)
	assign cur_phase = restart ? PHASE_BITS'(start_phase_q) : phase_acc_q;
	assign cur_count = restart ? '0 : count_q;

	// Block length: zero acts as one, large values saturate
	always_comb begin
		if (block_length_q == '0)
			eff_len = LEN_W'(1);
		else if (32'(block_length_q) > 32'(MAX_BLOCK))
			eff_len = LEN_W'(MAX_BLOCK);
		else
			eff_len = LEN_W'(block_length_q);
	end

	assign count_inc = LEN_W'(cur_count) + LEN_W'(1);
	assign last      = (count_inc >= eff_len);

	// State update on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			count_q     <= '0;
		end else if (take) begin
			phase_acc_q <= cur_phase + PHASE_BITS'(phase_step_q);
			count_q     <= last ? '0 : CNT_W'(count_inc);
		end
	end

	// Quadrant and mirrored table addresses
	assign quad     = cur_phase[PHASE_BITS-1 -: 2];
	assign frac     = cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
	assign addr_fwd = {1'b0, frac};
	assign addr_rev = {1'b1, {TABLE_ADDR_BITS{1'b0}}} - addr_fwd;

	// Cosine is the next quadrant, so its mirroring is the opposite of sine's
	assign sin_addr = quad[0] ? addr_rev : addr_fwd;
	assign cos_addr = quad[0] ? addr_fwd : addr_rev;

	assign ctrl.quad      = quad;
	assign ctrl.block_end = last;
	assign ctrl.cplx      = complex_mode_q;

endmodule

`default_nettype wire

/* design/nco_out.sv */
// Quadrant sign restore and output register.
`default_nettype none

module nco_out #(
	parameter int AMP_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid_s1,
	input  wire nco_pkg::ctrl_t             ctrl_s1,
	input  wire logic [AMP_BITS-2:0]        sin_mag,
	input  wire logic [AMP_BITS-2:0]        cos_mag,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic signed [AMP_BITS-1:0]      cos_value,
	output logic signed [AMP_BITS-1:0]      sin_value,
	output logic                            block_end,
	output logic                            adv
);
	import nco_pkg::*;

	logic                       valid_s2;
	logic signed [AMP_BITS-1:0] cos_s2;
	logic signed [AMP_BITS-1:0] sin_s2;
	logic                       end_s2;

	logic [1:0]                 cos_quad;
	logic signed [AMP_BITS-1:0] sin_pos;
	logic signed [AMP_BITS-1:0] cos_pos;
	logic signed [AMP_BITS-1:0] sin_nxt;
	logic signed [AMP_BITS-1:0] cos_nxt;

	// Output stage takes new data when empty or being drained
	assign adv = !valid_s2 || out_ready;

	// Negate in the lower half-turn; cosine uses the following quadrant and is zero in real mode
	assign cos_quad = ctrl_s1.quad + 2'd1;
	assign sin_pos  = signed'({1'b0, sin_mag});
	assign cos_pos  = signed'({1'b0, cos_mag});
	assign sin_nxt  = ctrl_s1.quad[1] ? -sin_pos : sin_pos;
	assign cos_nxt  = !ctrl_s1.cplx ? '0 : (cos_quad[1] ? -cos_pos : cos_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s2 <= cos_nxt;
			sin_s2 <= sin_nxt;
			end_s2 <= ctrl_s1.block_end;
		end
	end

	assign out_valid = valid_s2;
	assign cos_value = cos_s2;
	assign sin_value = sin_s2;
	assign block_end = end_s2;

endmodule

`default_nettype wire

/* tb/sv/phase_accumulator_oscillator_tb.sv */
// Self-checking testbench for the phase accumulator oscillator with a built-in sample predictor.
`timescale 1ns / 1ps

module phase_accumulator_oscillator_tb;
	import nco_pkg::*;

	localparam int ROM_ADDR_BITS = 10;
	localparam int QTR_LEN = 1 << ROM_ADDR_BITS;
	localparam longint unsigned FULL_SCALE = 32767;
	localparam int MAX_LEN = 4096;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic signed [15:0] cos_v;
		logic signed [15:0] sin_v;
		logic               blk_end;
	} nco_sample_t;

	// Clock, reset and ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] cos_value;
	logic signed [15:0] sin_value;
	logic block_end;

	// Predictor state, mirrors the block's registers
	int sine_rom [0:QTR_LEN];
	logic [31:0] phase_now = '0;
	logic [11:0] block_pos = '0;
	logic [31:0] step_reg = '0;
	logic [31:0] start_reg = '0;
	logic        complex_reg = 1'b1;
	logic [12:0] len_reg = 13'd4096;

	nco_sample_t pending_samples [$];
	nco_sample_t got, want;

	// Run bookkeeping
	int mismatches = 0;
	int samples_checked = 0;
	int samples_sent = 0;
	int restarts_sent = 0;
	int block_ends_seen = 0;
	int cfg_writes = 0;
	int unsigned cycle_count = 0;

	// Stall control
	bit tx_jitter = 1'b0;
	bit rx_jitter = 1'b0;
	bit hold_req = 1'b0;

	phase_accumulator_oscillator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cos_value (cos_value),
		.sin_value (sin_value),
		.block_end (block_end)
	);

	always #4 clk = ~clk;

	// Quarter-wave table: Q30 Taylor sine, scaled to full amplitude, half up
	function automatic void fill_sine_rom();
		longint unsigned ang, ang_sq, term, scaled;
		longint partial;
		for (int i = 0; i <= QTR_LEN; i++) begin
			ang = (64'(i) * HALF_PI_Q30 + 64'(QTR_LEN / 2)) >> ROM_ADDR_BITS;
			ang_sq = (ang * ang) >> 30;
			term = ang;
			partial = longint'(ang);
			for (int k = 1; k <= 6; k++) begin
				term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1)
					partial = partial - longint'(term);
				else
					partial = partial + longint'(term);
			end
			if (partial < 0)
				partial = 0;
			scaled = (64'(partial) * FULL_SCALE + (64'd1 << 29)) >> 30;
			if (scaled > FULL_SCALE)
				scaled = FULL_SCALE;
			sine_rom[i] = int'(scaled);
		end
	endfunction

	// Table value for a quadrant and offset within it
	function automatic logic signed [15:0] wave_point(input logic [1:0] quad,
			input logic [9:0] offs);
		int v;
		v = quad[0] ? sine_rom[QTR_LEN - int'(offs)] : sine_rom[offs];
		if (quad[1])
			v = -v;
		return 16'(v);
	endfunction

	// Expected output for one sample request; advances phase and block position
	function automatic nco_sample_t predict_sample(input logic reload);
		nco_sample_t s;
		logic [11:0] idx;
		int eff_len;
		if (reload) begin
			phase_now = start_reg;
			block_pos = '0;
		end
		idx = phase_now[31:20];
		s.sin_v = wave_point(idx[11:10], idx[9:0]);
		s.cos_v = complex_reg ? wave_point(idx[11:10] + 2'd1, idx[9:0]) : 16'sd0;
		if (len_reg == 0)
			eff_len = 1;
		else if (int'(len_reg) > MAX_LEN)
			eff_len = MAX_LEN;
		else
			eff_len = int'(len_reg);
		if (int'(block_pos) + 1 >= eff_len) begin
			s.blk_end = 1'b1;
			block_pos = '0;
		end else begin
			s.blk_end = 1'b0;
			block_pos = block_pos + 12'd1;
		end
		phase_now = phase_now + step_reg;
		return s;
	endfunction

	// Monitor: register writes, sample transfers and result checks
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			cfg_writes++;
			case (cfg_index)
				REG_PHASE_STEP:   step_reg = cfg_data;
				REG_START_PHASE:  start_reg = cfg_data;
				REG_COMPLEX_MODE: complex_reg = cfg_data[0];
				REG_BLOCK_LENGTH: len_reg = cfg_data[12:0];
				default: ;
			endcase
		end
		if (in_valid && in_ready)
			pending_samples.push_back(predict_sample(restart));
		if (out_valid && out_ready) begin
			got = '{cos_value, sin_value, block_end};
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: output transfer with no sample outstanding: cos %0d sin %0d end %0b",
						got.cos_v, got.sin_v, got.blk_end);
			end else begin
				want = pending_samples.pop_front();
				samples_checked++;
				if (want.blk_end)
					block_ends_seen++;
				if (got.cos_v !== want.cos_v || got.sin_v !== want.sin_v ||
						got.blk_end !== want.blk_end) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("ERROR: sample %0d: cos exp %0d got %0d, sin exp %0d got %0d, end exp %0b got %0b",
							samples_checked, want.cos_v, got.cos_v, want.sin_v, got.sin_v,
							want.blk_end, got.blk_end);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d samples outstanding",
				cycle_count, pending_samples.size());
			$display("phase_accumulator_oscillator: mismatch");
			$finish;
		end
	end

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Output side: random stalls plus an on-demand long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = 300;
				out_ready <= 1'b0;
			end else if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (rx_jitter && $urandom_range(0, 99) < 30) begin
				stall_left = pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// One sample request; valid stays high across back-to-back transfers
	task automatic send_sample(input logic reload);
		int gap;
		gap = tx_jitter ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		restart <= reload;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		samples_sent++;
		if (reload)
			restarts_sent++;
	endtask

	task automatic send_run(input int count, input int restart_pct);
		for (int i = 0; i < count; i++)
			send_sample($urandom_range(0, 99) < restart_pct);
	endtask

	// Stop offering, wait for every expected sample, then cover the pipeline
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reset values: zero phase and step, complex output
	task automatic test_reset_state();
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b1);
		wait_drained();
	endtask

	// Quadrant boundaries, phase wrap from the top, step extremes
	task automatic test_quadrants();
		write_reg(REG_START_PHASE, 32'hFFFF_FFFF);
		write_reg(REG_PHASE_STEP, 32'h4000_0000);
		send_sample(1'b1);
		repeat (4) send_sample(1'b0);
		wait_drained();
		write_reg(REG_PHASE_STEP, 32'h8000_0000);
		send_sample(1'b0);
		send_sample(1'b0);
		wait_drained();
		write_reg(REG_PHASE_STEP, 32'h7FFF_FFFF);
		send_sample(1'b0);
		send_sample(1'b0);
		wait_drained();
		write_reg(REG_PHASE_STEP, 32'h0010_0000);
		write_reg(REG_START_PHASE, 32'h0000_0000);
		send_sample(1'b1);
		send_sample(1'b0);
		wait_drained();
	endtask

	// Real mode: cosine field forced to zero
	task automatic test_real_mode();
		write_reg(REG_COMPLEX_MODE, 32'hFFFF_FFFE);
		write_reg(REG_PHASE_STEP, 32'h1234_5678);
		repeat (3) send_sample(1'b0);
		wait_drained();
		write_reg(REG_COMPLEX_MODE, 32'h0000_0001);
	endtask

	// Zero and one lengths, length lowered mid-block, restart at block end
	task automatic test_block_length();
		write_reg(REG_BLOCK_LENGTH, 32'd1);
		send_sample(1'b1);
		send_sample(1'b0);
		wait_drained();
		write_reg(REG_BLOCK_LENGTH, 32'd0);
		send_sample(1'b0);
		send_sample(1'b0);
		wait_drained();
		write_reg(REG_BLOCK_LENGTH, 32'd4096);
		repeat (3) send_sample(1'b0);
		wait_drained();
		write_reg(REG_BLOCK_LENGTH, 32'd2);
		send_sample(1'b0);
		wait_drained();
		write_reg(REG_BLOCK_LENGTH, 32'd3);
		send_sample(1'b1);
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b1);
		send_sample(1'b0);
		send_sample(1'b0);
		wait_drained();
	endtask

	// Receiver holds off for a long stretch while samples keep coming
	task automatic test_backpressure();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		write_reg(REG_PHASE_STEP, $urandom);
		write_reg(REG_BLOCK_LENGTH, 32'd5);
		hold_req = 1'b1;
		send_run(40, 5);
		wait_drained();
	endtask

	task automatic load_random_config();
		logic [31:0] step_val;
		logic [12:0] len_val;
		case ($urandom_range(0, 5))
			0: step_val = 32'h8000_0000;
			1: step_val = 32'h7FFF_FFFF;
			2: step_val = 32'($urandom_range(0, 2000)) - 32'd1000;
			default: step_val = $urandom;
		endcase
		case ($urandom_range(0, 7))
			0: len_val = 13'd0;
			1: len_val = 13'd1;
			2: len_val = 13'd4096;
			3: len_val = 13'($urandom_range(4097, 8191));
			default: len_val = 13'($urandom_range(2, 50));
		endcase
		write_reg(REG_PHASE_STEP, step_val);
		write_reg(REG_START_PHASE, $urandom);
		write_reg(REG_COMPLEX_MODE, $urandom);
		write_reg(REG_BLOCK_LENGTH, {19'($urandom), len_val});
	endtask

	// Random settings per phase, random restarts and stalls
	task automatic test_random_phases();
		for (int p = 0; p < 8; p++) begin
			tx_jitter = (p % 3 != 0);
			rx_jitter = (p % 4 != 1);
			load_random_config();
			send_sample($urandom_range(0, 1));
			send_run(90, 8);
			wait_drained();
		end
	endtask

	// Oversized length saturates: a full-rate run with no early block end
	task automatic test_long_block();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		write_reg(REG_BLOCK_LENGTH, 32'h0000_1FFF);
		write_reg(REG_PHASE_STEP, $urandom);
		write_reg(REG_COMPLEX_MODE, 32'd1);
		send_sample(1'b1);
		send_run(60, 0);
		wait_drained();
	endtask

	initial begin
		fill_sine_rom();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_quadrants();
		test_real_mode();
		test_block_length();
		test_backpressure();
		test_random_phases();
		test_long_block();
		wait_drained();
		if (pending_samples.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d expected samples never came out", pending_samples.size());
		end
		$display("Covered %0d sample requests (%0d with restart) and %0d register writes;",
			samples_sent, restarts_sent, cfg_writes);
		$display("%0d outputs checked, %0d block ends, %0d mismatches.",
			samples_checked, block_ends_seen, mismatches);
		if (mismatches == 0)
			$display("phase_accumulator_oscillator: match");
		else
			$display("phase_accumulator_oscillator: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
design/nco_pkg.sv
design/nco_rom.sv
design/nco_phase.sv
design/nco_out.sv
design/phase_accumulator_oscillator.sv
tb/sv/phase_accumulator_oscillator_tb.sv
